/* hdl/ocm_pkg.sv */
// Shared types and constants for the occupancy grid cell merge block.
// No dependencies; every other file of the block but ocm_ram imports this package.

package ocm_pkg;

  // Default geometry of the global grid.
  localparam int DEF_GRID_SIDE          = 2048;
  localparam int DEF_UPDATE_BLOCK_SHIFT = 1;

  // Configuration port geometry and register indexes.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_HALF_SIZE  = 2'd2;
  localparam logic [1:0] REG_SAFE_DIST  = 2'd3;

  // Register reset values.
  localparam logic [22:0] RST_HALF_SIZE = 23'd2560;
  localparam logic [22:0] RST_SAFE_DIST = 23'd5120;

  // Cell value codes and merge thresholds.
  localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;
  localparam logic signed [7:0] OCC_LOW_LIMIT = 8'sd90;
  localparam logic signed [7:0] OCC_SAT_LIMIT = 8'sd119;
  localparam logic signed [7:0] OCC_FORCED    = 8'sd100;

  // Reciprocals for the exact division of magnitudes by 5 and by 25.
  localparam int          RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP_5     = 14'd13108;
  localparam logic [13:0] RECIP_25    = 14'd2622;

  // Configuration register file contents.
  typedef struct packed {
    logic [23:0] origin_x;
    logic [23:0] origin_y;
    logic [22:0] half_size;
    logic [22:0] safe_dist;
  } ocm_cfg_t;

  // One local cell as accepted from the input channel.
  typedef struct packed {
    logic [11:0] cell_col;
    logic [11:0] cell_row;
    logic [7:0]  local_value;
    logic [23:0] robot_x;
    logic [23:0] robot_y;
    logic [23:0] last_x;
    logic [23:0] last_y;
    logic        last_valid;
  } ocm_in_t;

  // One merge result for the output channel.
  typedef struct packed {
    logic        written;
    logic        out_of_range;
    logic [10:0] global_col;
    logic [10:0] global_row;
    logic [7:0]  new_value;
  } ocm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic load_in;
    logic pos_en;
    logic diff_en;
    logic addr_en;
    logic rd_en;
    logic eval_en;
    logic commit_en;
    logic early_en;
  } ocm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic skip;
    logic out_free;
  } ocm_sts_t;

endpackage

/* hdl/ocm_if.sv */
// Valid/ready channel interfaces for the cell merge input and result streams.
// Depends on ocm_pkg for nothing but style; widths follow the item fields.

interface ocm_in_if import ocm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [11:0] cell_col;
  logic [11:0] cell_row;
  logic [7:0]  local_value;
  logic [23:0] robot_x;
  logic [23:0] robot_y;
  logic [23:0] last_x;
  logic [23:0] last_y;
  logic        last_valid;

  modport source (output valid, cell_col, cell_row, local_value, robot_x, robot_y,
                  last_x, last_y, last_valid, input ready);
  modport sink (input valid, cell_col, cell_row, local_value, robot_x, robot_y,
                last_x, last_y, last_valid, output ready);
endinterface

interface ocm_out_if import ocm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        written;
  logic        out_of_range;
  logic [10:0] global_col;
  logic [10:0] global_row;
  logic [7:0]  new_value;

  modport source (output valid, written, out_of_range, global_col, global_row, new_value,
                  input ready);
  modport sink (input valid, written, out_of_range, global_col, global_row, new_value,
                output ready);
endinterface

/* hdl/ocm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module ocm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ocm_cfg.sv */
// APB-style configuration register file of the cell merge block.
// Depends on ocm_pkg for the register indexes, reset values and ocm_cfg_t.

module ocm_cfg import ocm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ocm_cfg_t           cfg_o
);

  ocm_cfg_t cfg_q;
  logic     wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access phase of a write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x  <= '0;
      cfg_q.origin_y  <= '0;
      cfg_q.half_size <= RST_HALF_SIZE;
      cfg_q.safe_dist <= RST_SAFE_DIST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ORIGIN_X:  cfg_q.origin_x  <= pwdata[23:0];
        REG_ORIGIN_Y:  cfg_q.origin_y  <= pwdata[23:0];
        REG_HALF_SIZE: cfg_q.half_size <= pwdata[22:0];
        REG_SAFE_DIST: cfg_q.safe_dist <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // Read-back of the register values.
  always_comb begin
    case (paddr[3:2])
      REG_ORIGIN_X:  prdata = {8'b0, cfg_q.origin_x};
      REG_ORIGIN_Y:  prdata = {8'b0, cfg_q.origin_y};
      REG_HALF_SIZE: prdata = {9'b0, cfg_q.half_size};
      REG_SAFE_DIST: prdata = {9'b0, cfg_q.safe_dist};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/ocm_ctrl.sv */
// Sequencing state machine of the cell merge block.
// Depends on ocm_pkg for the command and status structs.

module ocm_ctrl import ocm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ocm_sts_t sts_i,
  output ocm_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_POS    = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_ADDR   = 3'd4;
  localparam logic [2:0] S_EARLY  = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_COMMIT = 3'd7;

  logic [2:0] state_q, state_d;
  logic       eval_q, eval_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode. The blend evaluation is a sub-step of the
  // commit state, marked by eval_q, so the state fits three bits.
  always_comb begin
    state_d = state_q;
    eval_d  = eval_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_POS;
        end
      end
      S_POS: begin
        cmd_o.pos_en = 1'b1;
        state_d      = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.addr_en = 1'b1;
        state_d       = sts_i.skip ? S_EARLY : S_READ;
      end
      S_EARLY: begin
        if (sts_i.out_free) begin
          cmd_o.early_en = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        eval_d      = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        if (eval_q) begin
          cmd_o.eval_en = 1'b1;
          eval_d        = 1'b0;
        end else if (sts_i.out_free) begin
          cmd_o.commit_en = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        eval_d  = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      eval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      eval_q  <= eval_d;
    end
  end

endmodule

/* hdl/ocm_dp.sv */
// Datapath of the cell merge block: position arithmetic, grid and flag RAMs,
// blend unit and result register. Depends on ocm_pkg and ocm_ram.

module ocm_dp import ocm_pkg::*; #(
  parameter int GRID_SIDE          = DEF_GRID_SIDE,
  parameter int UPDATE_BLOCK_SHIFT = DEF_UPDATE_BLOCK_SHIFT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ocm_cmd_t cmd_i,
  output ocm_sts_t sts_o,
  input  ocm_cfg_t cfg_i,
  input  ocm_in_t  in_item_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output ocm_out_t out_item_o
);

  localparam int BLOCK_SIDE = (GRID_SIDE + (1 << UPDATE_BLOCK_SHIFT) - 1) >> UPDATE_BLOCK_SHIFT;
  localparam int CELLS      = GRID_SIDE * GRID_SIDE;
  localparam int BLOCKS     = BLOCK_SIDE * BLOCK_SIDE;
  localparam int CELL_AW    = $clog2(CELLS);
  localparam int BLK_AW     = BLOCKS > 1 ? $clog2(BLOCKS) : 1;
  localparam int IX_W       = $clog2(GRID_SIDE);

  // Accepted item.
  ocm_in_t item_q;

  // Position stage.
  logic [24:0] px_q, py_q;

  // Distance stage.
  logic [25:0] dxa, dxb, dya, dyb;
  logic [24:0] dx_q, dy_q;
  logic        offgrid_q;
  logic        robot_blk_q;
  logic [15:0] lcx, lcy;

  // Address stage.
  logic               in_win, far;
  logic [IX_W-1:0]    ix, iy, ux, uy;
  logic [CELL_AW-1:0] cidx_q;
  logic [BLK_AW-1:0]  bidx_q;
  logic               oor_q, far_q;
  logic [10:0]        gcol_q, grow_q;

  // Memories.
  logic               grid_we, flag_we;
  logic [CELL_AW-1:0] grid_waddr;
  logic [BLK_AW-1:0]  flag_waddr;
  logic [7:0]         grid_wdata, grid_rdata;
  logic               flag_wdata, flag_rdata;

  // Clearing pass counter.
  logic [CELL_AW-1:0] clr_cnt_q;

  // Blend evaluation.
  logic signed [7:0]  g, l;
  logic [10:0]        sum5;
  logic [12:0]        sum25, num, num_neg;
  logic               use_div, div25;
  logic [7:0]         direct;
  logic [7:0]         val_q;
  logic               use_div_q, div25_q, neg_q, written_q, wr_flag_q;
  logic [11:0]        mag_q;

  // Commit.
  logic [13:0] recip;
  logic [25:0] prod;
  logic [8:0]  quot, quot_s;
  logic [7:0]  result;

  // Output register.
  ocm_out_t out_q;
  logic     out_valid_q;

  // Payload registers of the processing steps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_item_i;
    end
    if (cmd_i.pos_en) begin
      px_q <= {5'b0, item_q.cell_col, 8'h80} + {cfg_i.origin_x[23], cfg_i.origin_x};
      py_q <= {5'b0, item_q.cell_row, 8'h80} + {cfg_i.origin_y[23], cfg_i.origin_y};
    end
    if (cmd_i.diff_en) begin
      dx_q        <= dxa[25] ? dxb[24:0] : dxa[24:0];
      dy_q        <= dya[25] ? dyb[24:0] : dya[24:0];
      offgrid_q   <= px_q[24] || py_q[24] ||
                     ({1'b0, px_q[23:8]} >= 17'(GRID_SIDE)) ||
                     ({1'b0, py_q[23:8]} >= 17'(GRID_SIDE));
      robot_blk_q <= item_q.last_valid && !item_q.last_x[23] && !item_q.last_y[23] &&
                     ((lcx >> UPDATE_BLOCK_SHIFT) == (px_q[23:8] >> UPDATE_BLOCK_SHIFT)) &&
                     ((lcy >> UPDATE_BLOCK_SHIFT) == (py_q[23:8] >> UPDATE_BLOCK_SHIFT));
    end
    if (cmd_i.addr_en) begin
      oor_q  <= in_win && offgrid_q;
      far_q  <= far;
      cidx_q <= CELL_AW'(ix) + CELL_AW'(iy) * CELL_AW'(GRID_SIDE);
      bidx_q <= BLK_AW'(ux) * BLK_AW'(BLOCK_SIDE) + BLK_AW'(uy);
      gcol_q <= px_q[18:8];
      grow_q <= py_q[18:8];
    end
    if (cmd_i.eval_en) begin
      val_q     <= direct;
      use_div_q <= use_div;
      div25_q   <= div25;
      neg_q     <= num[12];
      mag_q     <= num[12] ? num_neg[11:0] : num[11:0];
      written_q <= !flag_rdata;
      wr_flag_q <= !flag_rdata && robot_blk_q;
    end
  end

  // Absolute distances to the robot, both orders of subtraction side by side.
  assign dxa = {px_q[24], px_q} - {{2{item_q.robot_x[23]}}, item_q.robot_x};
  assign dxb = {{2{item_q.robot_x[23]}}, item_q.robot_x} - {px_q[24], px_q};
  assign dya = {py_q[24], py_q} - {{2{item_q.robot_y[23]}}, item_q.robot_y};
  assign dyb = {{2{item_q.robot_y[23]}}, item_q.robot_y} - {py_q[24], py_q};
  assign lcx = {1'b0, item_q.last_x[22:8]};
  assign lcy = {1'b0, item_q.last_y[22:8]};

  // Window tests and cell and block indexes.
  assign in_win = (dx_q <= {2'b0, cfg_i.half_size}) && (dy_q <= {2'b0, cfg_i.half_size});
  assign far    = (dx_q >= {2'b0, cfg_i.safe_dist}) || (dy_q >= {2'b0, cfg_i.safe_dist});
  assign ix     = px_q[8 +: IX_W];
  assign iy     = py_q[8 +: IX_W];
  assign ux     = ix >> UPDATE_BLOCK_SHIFT;
  assign uy     = iy >> UPDATE_BLOCK_SHIFT;

  // Merge rule on the stored value: pick a direct value or a division.
  assign g       = grid_rdata;
  assign l       = item_q.local_value;
  assign sum5    = {{3{g[7]}}, g} + {l[7], l, 2'b00};
  assign sum25   = {g[7], g, 4'b0} + {{2{g[7]}}, g, 3'b0} + {{5{l[7]}}, l};
  assign num     = div25 ? sum25 : {{2{sum5[10]}}, sum5};
  assign num_neg = -num;

  always_comb begin
    use_div = 1'b0;
    div25   = 1'b0;
    direct  = g;
    if (flag_rdata) begin
      direct = g;
    end else if (g == CELL_UNKNOWN) begin
      direct = l;
    end else if (g >= 8'sd0 && g < OCC_LOW_LIMIT) begin
      use_div = (l != CELL_UNKNOWN);
    end else if (l >= OCC_SAT_LIMIT || g >= OCC_SAT_LIMIT) begin
      direct = OCC_FORCED;
    end else if (l != CELL_UNKNOWN) begin
      use_div = 1'b1;
      div25   = !far_q;
    end
  end

  // Truncating division of the magnitude by reciprocal multiplication.
  assign recip  = div25_q ? RECIP_25 : RECIP_5;
  assign prod   = mag_q * recip;
  assign quot   = prod[RECIP_SHIFT +: 9];
  assign quot_s = neg_q ? -quot : quot;
  assign result = use_div_q ? quot_s[7:0] : val_q;

  // Clearing pass after reset: unknown cells and cleared block flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_en && !sts_o.clear_last) begin
      clr_cnt_q <= clr_cnt_q + CELL_AW'(1);
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == CELL_AW'(CELLS - 1));
  assign sts_o.skip       = !in_win || offgrid_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Memory write selection between the clearing pass and the write-back.
  assign grid_we    = cmd_i.clear_en || (cmd_i.commit_en && written_q);
  assign grid_waddr = cmd_i.clear_en ? clr_cnt_q : cidx_q;
  assign grid_wdata = cmd_i.clear_en ? CELL_UNKNOWN : result;
  assign flag_we    = (cmd_i.clear_en && ({1'b0, clr_cnt_q} < (CELL_AW + 1)'(BLOCKS))) ||
                      (cmd_i.commit_en && wr_flag_q);
  assign flag_waddr = cmd_i.clear_en ? clr_cnt_q[BLK_AW-1:0] : bidx_q;
  assign flag_wdata = !cmd_i.clear_en;

  ocm_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cidx_q),
    .rdata_o (grid_rdata)
  );

  ocm_ram #(
    .WIDTH (1),
    .DEPTH (BLOCKS)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (bidx_q),
    .rdata_o (flag_rdata)
  );

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_en) begin
      out_q.written      <= written_q;
      out_q.out_of_range <= 1'b0;
      out_q.global_col   <= gcol_q;
      out_q.global_row   <= grow_q;
      out_q.new_value    <= result;
    end else if (cmd_i.early_en) begin
      out_q.written      <= 1'b0;
      out_q.out_of_range <= oor_q;
      out_q.global_col   <= '0;
      out_q.global_row   <= '0;
      out_q.new_value    <= '0;
    end
  end

  // Result valid flag; cleared when the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_en || cmd_i.early_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/occupancy_grid_cell_merge.sv */
// Top level of the occupancy grid cell merge block.
// Depends on ocm_pkg, ocm_if, ocm_cfg, ocm_ctrl, ocm_dp and ocm_ram.

// Merges one local occupancy cell per input transaction into a global grid of
// GRID_SIDE x GRID_SIDE signed 8-bit cells with one done flag per update block,
// and returns exactly one result transaction per cell. The sequencer steps a
// merged cell through centre arithmetic, distance, address, the registered read
// of the grid and flag RAMs, the blend and the write-back over their single
// write port; a cell that is skipped (outside the window or off the grid) is
// answered straight after the address step. Each result sits in an output
// register, so the next cell is taken while a result waits. After reset a
// clearing pass writes every grid cell to unknown and every block flag clear,
// one address a cycle over all GRID_SIDE*GRID_SIDE addresses (4194304 at the
// default size); no cell is accepted during it, while configuration writes are
// taken as usual.

module occupancy_grid_cell_merge import ocm_pkg::*; #(
  parameter int GRID_SIDE          = DEF_GRID_SIDE,
  parameter int UPDATE_BLOCK_SHIFT = DEF_UPDATE_BLOCK_SHIFT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ocm_in_if.sink             in_ch_i,
  ocm_out_if.source          out_ch_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ocm_cfg_t cfg;
  ocm_cmd_t cmd;
  ocm_sts_t sts;
  ocm_in_t  in_item;
  ocm_out_t out_item;
  logic     in_ready;
  logic     out_valid;

  // Pack the input channel payload.
  assign in_item.cell_col    = in_ch_i.cell_col;
  assign in_item.cell_row    = in_ch_i.cell_row;
  assign in_item.local_value = in_ch_i.local_value;
  assign in_item.robot_x     = in_ch_i.robot_x;
  assign in_item.robot_y     = in_ch_i.robot_y;
  assign in_item.last_x      = in_ch_i.last_x;
  assign in_item.last_y      = in_ch_i.last_y;
  assign in_item.last_valid  = in_ch_i.last_valid;
  assign in_ch_i.ready       = in_ready;

  // Drive the result channel.
  assign out_ch_o.valid        = out_valid;
  assign out_ch_o.written      = out_item.written;
  assign out_ch_o.out_of_range = out_item.out_of_range;
  assign out_ch_o.global_col   = out_item.global_col;
  assign out_ch_o.global_row   = out_item.global_row;
  assign out_ch_o.new_value    = out_item.new_value;

  ocm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ocm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ocm_dp #(
    .GRID_SIDE          (GRID_SIDE),
    .UPDATE_BLOCK_SHIFT (UPDATE_BLOCK_SHIFT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg),
    .in_item_i   (in_item),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

endmodule
